// ===== src/dctcp_window_update_top_macros.svh =====
// Assertion macros shared by the DCTCP window update block.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef DCTCP_WINDOW_UPDATE_TOP_MACROS_SVH
`define DCTCP_WINDOW_UPDATE_TOP_MACROS_SVH

// same-cycle implication
`define DWU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DWU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dwu_pkg.sv =====
// Package for the DCTCP window update block: field widths, register indexes,
// reset values and the command/status types between controller and datapath.
`timescale 1ns / 1ps

package dwu_pkg;

    localparam int WIN_W      = 32;
    localparam int SEG_W      = 16;
    localparam int CNT_W      = 16;
    localparam int SEL_W      = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_SEG_SIZE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_WINDOW  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_MARK   = 2'd2;

    localparam logic [SEG_W-1:0] SEG_SIZE_RST   = 16'd1436;
    localparam logic [WIN_W-1:0] MAX_WINDOW_RST = 32'hFFFF_FFFF;
    localparam logic [WIN_W-1:0] INIT_MARK_RST  = 32'd2872;

    typedef struct packed {
        logic load;
        logic read;
        logic step;
        logic test;
        logic div_step;
        logic alpha;
        logic mul;
        logic clamp;
        logic write;
    } t_dwu_cmd;

    typedef struct packed {
        logic need_update;
        logic div_last;
        logic alpha_nz;
    } t_dwu_sts;

endpackage

// ===== src/dwu_ctrl.sv =====
// Controller state machine for the DCTCP window update block.
// Uses dwu_pkg command/status types and the assertion macros header.
`timescale 1ns / 1ps
`include "dctcp_window_update_top_macros.svh"

module dwu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  dwu_pkg::t_dwu_sts i_sts,
    output dwu_pkg::t_dwu_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_STEP,
        S_TEST,
        S_DIV,
        S_ALPHA,
        S_MUL,
        S_CLAMP,
        S_WRITE
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && r_in_ready && i_in_valid;
        o_cmd.read     = (r_state == S_READ);
        o_cmd.step     = (r_state == S_STEP);
        o_cmd.test     = (r_state == S_TEST);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.alpha    = (r_state == S_ALPHA);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.clamp    = (r_state == S_CLAMP);
        o_cmd.write    = (r_state == S_WRITE) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.write) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (r_in_ready && i_in_valid) begin
                        r_state    <= S_READ;
                        r_in_ready <= 1'b0;
                    end
                end
                S_READ:  r_state <= S_STEP;
                S_STEP:  r_state <= S_TEST;
                S_TEST:  r_state <= i_sts.need_update ? S_DIV : S_WRITE;
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_ALPHA;
                    end
                end
                S_ALPHA: r_state <= S_MUL;
                S_MUL:   r_state <= i_sts.alpha_nz ? S_CLAMP : S_WRITE;
                S_CLAMP: r_state <= S_WRITE;
                S_WRITE: begin
                    if (slot_free) begin
                        r_in_ready <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DWU_ASSERT_NXT(a_single_item, o_cmd.load, !o_in_ready, "second item taken while busy")
    `DWU_ASSERT_NXT(a_no_update_path,
        (r_state == S_TEST) && !i_sts.need_update, r_state == S_WRITE,
        "ack without update did not go to write")
    `DWU_ASSERT_NXT(a_div_exit,
        (r_state == S_DIV) && i_sts.div_last, r_state == S_ALPHA,
        "divider did not hand over to alpha step")
    `DWU_ASSERT_NXT(a_result_posted, o_cmd.write, o_out_valid && o_in_ready,
        "result not posted after state write")
    `DWU_ASSERT_IMP(a_ready_idle, o_in_ready, r_state == S_IDLE, "ready outside idle")

endmodule

// ===== src/dwu_datapath.sv =====
// Datapath for the DCTCP window update block: config registers, per-slice
// state memories, bit-serial divider, alpha filter, window scaling, result.
// Uses dwu_pkg constants and types.
`timescale 1ns / 1ps

module dwu_datapath #(
    parameter int SLICES          = 8,
    parameter int ALPHA_FRAC_BITS = 16,
    parameter int AW              = ALPHA_FRAC_BITS + 1,
    parameter int OUT_DW          = ((2 * dwu_pkg::WIN_W + AW + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dwu_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dwu_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_kind,
    input  logic [dwu_pkg::SEL_W-1:0]      i_slice_sel,
    input  logic                           i_ecn_mark,
    input  logic [dwu_pkg::WIN_W-1:0]      i_cur_window,
    input  logic [dwu_pkg::WIN_W-1:0]      i_cur_thresh,
    input  dwu_pkg::t_dwu_cmd              i_cmd,
    output dwu_pkg::t_dwu_sts              o_sts,
    output logic [OUT_DW-1:0]              o_out_data,
    output logic                           o_out_updated
);

    localparam int FB     = ALPHA_FRAC_BITS;
    localparam int SW     = (SLICES > 1) ? $clog2(SLICES) : 1;
    localparam int DCW    = $clog2(FB);
    localparam int SCL_W  = FB + 2;
    localparam int PROD_W = dwu_pkg::WIN_W + SCL_W;
    localparam int WW     = dwu_pkg::WIN_W;
    localparam int CW     = dwu_pkg::CNT_W;
    localparam logic [AW-1:0]    ALPHA_ONE = AW'(1) << FB;
    localparam logic [SCL_W-1:0] SCALE_TWO = SCL_W'(1) << (FB + 1);

    // config
    logic [dwu_pkg::SEG_W-1:0] r_seg;
    logic [WW-1:0]             r_max_win;
    logic [WW-1:0]             r_init_mark;

    // per-slice state
    logic [AW-1:0] r_mem_alpha  [SLICES];
    logic [CW-1:0] r_mem_seen   [SLICES];
    logic [CW-1:0] r_mem_marked [SLICES];
    logic [WW-1:0] r_mem_last   [SLICES];
    logic [SLICES-1:0] r_cnt_vld;
    logic [SLICES-1:0] r_win_vld;

    // item working registers
    logic          r_kind;
    logic          r_ecn;
    logic [SW-1:0] r_idx;
    logic [WW-1:0] r_win;
    logic [WW-1:0] r_thr;
    logic [AW-1:0] r_alpha;
    logic [CW-1:0] r_seen;
    logic [CW-1:0] r_marked;
    logic [WW-1:0] r_last;
    logic [WW-1:0] r_cmp_prod;
    logic          r_upd;
    logic [CW-1:0] r_rem;
    logic [FB-1:0] r_quo;
    logic [DCW-1:0] r_div_cnt;
    logic          r_f_cap;
    logic [PROD_W-1:0] r_prod;
    logic [OUT_DW-1:0] r_out_data;
    logic          r_out_upd;

    logic [CW-1:0]    seen_inc;
    logic [CW-1:0]    marked_inc;
    logic [WW-1:0]    loss_half;
    logic [WW-1:0]    loss_floor;
    logic [CW:0]      rem2;
    logic             rem_ge;
    logic [AW-1:0]    f_val;
    logic [AW+3:0]    alpha_sum;
    logic [AW-1:0]    alpha_new;
    logic [SCL_W-1:0] scale;
    logic [WW-1:0]    scaled;
    logic [WW-1:0]    seg_ext;
    logic [WW-1:0]    clamped;

    function automatic logic [SW-1:0] f_slice(input logic [dwu_pkg::SEL_W-1:0] sel);
        logic [6:0] v;
        v = 7'(sel);
        for (int i = 0; i < 8; i++) begin
            if (v >= 7'(SLICES)) begin
                v = v - 7'(SLICES);
            end
        end
        return v[SW-1:0];
    endfunction

    always_comb begin
        seen_inc   = (r_seen != {CW{1'b1}}) ? r_seen + CW'(1) : r_seen;
        marked_inc = (r_ecn && (r_marked != {CW{1'b1}})) ? r_marked + CW'(1) : r_marked;
        loss_half  = r_win >> 1;
        loss_floor = WW'({r_seg, 1'b0});
        rem2       = {r_rem, 1'b0};
        rem_ge     = rem2 >= {1'b0, r_seen};
        f_val      = r_f_cap ? ALPHA_ONE : AW'(r_quo);
        alpha_sum  = {r_alpha, 4'b0000} - (AW + 4)'(r_alpha) + (AW + 4)'(f_val);
        alpha_new  = (alpha_sum[AW+3:4] > ALPHA_ONE) ? ALPHA_ONE : alpha_sum[AW+3:4];
        scale      = SCALE_TWO - SCL_W'(r_alpha);
        scaled     = r_prod[FB+1 +: WW];
        seg_ext    = WW'(r_seg);
        if (scaled < seg_ext) begin
            clamped = seg_ext;
        end else if (scaled > r_max_win) begin
            clamped = r_max_win;
        end else begin
            clamped = scaled;
        end
    end

    assign o_sts.need_update = !r_kind && (r_cmp_prod >= r_last);
    assign o_sts.div_last    = (r_div_cnt == DCW'(FB - 1));
    assign o_sts.alpha_nz    = (r_alpha != '0);
    assign o_out_data        = r_out_data;
    assign o_out_updated     = r_out_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= dwu_pkg::SEG_SIZE_RST;
            r_max_win   <= dwu_pkg::MAX_WINDOW_RST;
            r_init_mark <= dwu_pkg::INIT_MARK_RST;
            r_cnt_vld   <= '0;
            r_win_vld   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    dwu_pkg::CFG_SEG_SIZE:   r_seg     <= i_cfg_wdata[dwu_pkg::SEG_W-1:0];
                    dwu_pkg::CFG_MAX_WINDOW: r_max_win <= i_cfg_wdata[WW-1:0];
                    dwu_pkg::CFG_INIT_MARK: begin
                        r_init_mark <= i_cfg_wdata[WW-1:0];
                        r_win_vld   <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.write) begin
                r_cnt_vld[r_idx] <= 1'b1;
                r_win_vld[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_ecn  <= i_ecn_mark;
            r_idx  <= f_slice(i_slice_sel);
            r_win  <= i_cur_window;
            r_thr  <= i_cur_thresh;
        end
        if (i_cmd.read) begin
            r_alpha  <= r_cnt_vld[r_idx] ? r_mem_alpha[r_idx]  : '0;
            r_seen   <= r_cnt_vld[r_idx] ? r_mem_seen[r_idx]   : '0;
            r_marked <= r_cnt_vld[r_idx] ? r_mem_marked[r_idx] : '0;
            r_last   <= r_win_vld[r_idx] ? r_mem_last[r_idx]   : r_init_mark;
        end
        if (i_cmd.step) begin
            if (r_kind) begin
                r_seen   <= '0;
                r_marked <= '0;
                r_thr    <= (loss_half > loss_floor) ? loss_half : loss_floor;
                r_last   <= r_win;
            end else begin
                r_seen   <= seen_inc;
                r_marked <= marked_inc;
                if (r_ecn && (r_thr > r_win)) begin
                    r_thr <= r_win;
                end
            end
            r_cmp_prod <= WW'(seen_inc) * WW'(r_seg);
        end
        if (i_cmd.test) begin
            r_upd     <= o_sts.need_update;
            r_rem     <= r_marked;
            r_quo     <= '0;
            r_div_cnt <= '0;
            r_f_cap   <= r_marked >= r_seen;
        end
        if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? CW'(rem2 - {1'b0, r_seen}) : rem2[CW-1:0];
            r_quo     <= {r_quo[FB-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + DCW'(1);
        end
        if (i_cmd.alpha) begin
            r_alpha  <= alpha_new;
            r_seen   <= '0;
            r_marked <= '0;
            r_last   <= r_win;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_win) * PROD_W'(scale);
        end
        if (i_cmd.clamp) begin
            r_win  <= clamped;
            r_thr  <= clamped;
            r_last <= clamped;
        end
        if (i_cmd.write) begin
            r_mem_alpha[r_idx]  <= r_alpha;
            r_mem_seen[r_idx]   <= r_seen;
            r_mem_marked[r_idx] <= r_marked;
            r_mem_last[r_idx]   <= r_last;
            r_out_data          <= OUT_DW'({r_alpha, r_thr, r_win});
            r_out_upd           <= r_upd;
        end
    end

endmodule

// ===== src/dctcp_window_update_top.sv =====
// DCTCP window update block, top level: stream ports and config write port.
// Instantiates dwu_ctrl and dwu_datapath; uses dwu_pkg.
//
// Input stream s_axis: one ack or loss event per item. Output stream m_axis:
// one result per item with the new window, threshold, alpha and update flag.
// Config: i_cfg_we with i_cfg_addr (0 segment size, 1 max window,
// 2 initial window mark) and i_cfg_wdata; write only while idle. Writing the
// initial window mark also resets every slice's stored window.
// One item is in work at a time. An ack that does not close a window and a
// loss post their result after the read, step, test and write states; an
// ack that closes a window also passes through the divider, alpha, multiply
// and clamp states, skipping clamp when alpha stays zero. The divider for
// marked/seen gives one quotient bit per cycle. The block becomes ready for
// the next item as the result is posted.
// The result sits in an output register: a stalled receiver does not block
// the next item, but the item after that waits until the register drains.
// Reset is synchronous, active low: per-slice state reads as reset values at
// once through valid bits, with no clearing pass; the block is ready at once.
`timescale 1ns / 1ps

module dctcp_window_update_top #(
    parameter int SLICES          = 8,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dwu_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [dwu_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cur_window, cur_thresh
    input  logic [dwu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind, slice_sel, ecn_mark
    input  logic [dwu_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // new_window, new_thresh, alpha_out, zero fill
    output logic [((2 * dwu_pkg::WIN_W + ALPHA_FRAC_BITS + 8) / 8) * 8 - 1:0] m_axis_tdata,
    // window_updated
    output logic [0:0]                        m_axis_tuser
);

    localparam int AW     = ALPHA_FRAC_BITS + 1;
    localparam int OUT_DW = ((2 * dwu_pkg::WIN_W + AW + 7) / 8) * 8;

    dwu_pkg::t_dwu_cmd cmd;
    dwu_pkg::t_dwu_sts sts;

    dwu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dwu_datapath #(
        .SLICES          (SLICES),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS),
        .AW              (AW),
        .OUT_DW          (OUT_DW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (s_axis_tuser[0]),
        .i_slice_sel   (s_axis_tuser[3:1]),
        .i_ecn_mark    (s_axis_tuser[4]),
        .i_cur_window  (s_axis_tdata[31:0]),
        .i_cur_thresh  (s_axis_tdata[63:32]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_data    (m_axis_tdata),
        .o_out_updated (m_axis_tuser[0])
    );

endmodule
